>>> rtl/bmpstg_pkg.sv
package bmpstg_pkg;

  // decode phases
  typedef enum logic [1:0] {
    PH_HEAD,
    PH_LEN,
    PH_DATA,
    PH_DONE
  } phase_t;

  // header layout
  localparam logic [31:0] HEADER_BYTES = 32'd14;
  localparam logic [31:0] OFFSET_FIRST = 32'd10;
  localparam logic [31:0] OFFSET_LAST  = 32'd13;
  localparam logic [31:0] POS_MAX      = 32'hFFFF_FFFF;

  // message framing
  localparam logic [3:0]  LEN_LAST_BIT  = 4'd15;
  localparam logic [3:0]  CHAR_LAST_BIT = 4'd6;
  localparam logic [15:0] CHAR_BITS     = 16'd7;

endpackage

>>> rtl/bmp_lsb_stego_extractor.sv
// channel   | handshake               | payload
// ----------+-------------------------+-------------------------------
// file in   | byte_valid / byte_stall | file_byte[7:0]
// char out  | char_valid / char_stall | character[6:0], last_character
//
// one byte per cycle while the output does not stall: an input register, one level of decode logic, a result register
// a character is on the output in the cycle after its last byte leaves the input register
// the 32-bit position compare against the pixel-data offset sets the decode path
// rst is synchronous and returns the block to the header phase at byte 0
// a stall on the output holds the result register; the input stalls only when
// a byte is waiting and the result register is full and stalled
module bmp_lsb_stego_extractor
  import bmpstg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] file_byte,
  output logic       char_valid,
  input  logic       char_stall,
  output logic [6:0] character,
  output logic       last_character
);

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // decode state
  phase_t      phase, phase_next;
  logic [31:0] byte_position, byte_position_next;
  logic [31:0] offset, offset_next;
  logic [15:0] length, length_next;
  logic [15:0] remaining, remaining_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [6:0]  accum, accum_next;

  // result of the current byte
  logic       res_valid;
  logic [6:0] res_char;
  logic       res_last;

  logic        move;
  logic        msg_bit;
  logic [31:0] pos_inc;
  logic [31:0] offset_cap;
  logic [15:0] length_full;
  logic [15:0] remaining_sub;

  assign move       = in_valid_q && (!char_valid || !char_stall);
  assign byte_stall = in_valid_q && !move;
  assign msg_bit    = in_byte_q[0];

  assign pos_inc       = (byte_position == POS_MAX) ? byte_position : byte_position + 32'd1;
  assign offset_cap    = {in_byte_q, offset[31:8]};
  assign length_full   = {msg_bit, length[15:1]};
  assign remaining_sub = remaining - CHAR_BITS;

  // input register transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (!byte_stall) begin
      in_valid_q <= byte_valid;
    end
    if (!byte_stall && byte_valid) begin
      in_byte_q <= file_byte;
    end
  end

  // next state and datapath
  always_comb begin
    phase_next         = phase;
    byte_position_next = byte_position;
    offset_next        = offset;
    length_next        = length;
    remaining_next     = remaining;
    bit_count_next     = bit_count;
    accum_next         = accum;
    if (move) begin
      unique case (phase)
        PH_HEAD: begin
          byte_position_next = pos_inc;
          if (byte_position < HEADER_BYTES) begin
            if (byte_position >= OFFSET_FIRST) begin
              offset_next = offset_cap;
            end
            if (byte_position == OFFSET_LAST && offset_cap < HEADER_BYTES) begin
              offset_next = HEADER_BYTES;
            end
          end else if (byte_position >= offset) begin
            // first length bit comes from this byte
            phase_next     = PH_LEN;
            length_next    = length_full;
            bit_count_next = 4'd1;
          end
        end
        PH_LEN: begin
          length_next = length_full;
          if (bit_count == LEN_LAST_BIT) begin
            bit_count_next = 4'd0;
            remaining_next = length_full;
            phase_next     = (length_full < CHAR_BITS) ? PH_DONE : PH_DATA;
          end else begin
            bit_count_next = bit_count + 4'd1;
          end
        end
        PH_DATA: begin
          accum_next = {msg_bit, accum[6:1]};
          if (bit_count == CHAR_LAST_BIT) begin
            bit_count_next = 4'd0;
            remaining_next = remaining_sub;
            if (remaining_sub < CHAR_BITS) begin
              phase_next = PH_DONE;
            end
          end else begin
            bit_count_next = bit_count + 4'd1;
          end
        end
        PH_DONE: begin
          phase_next = PH_DONE;
        end
        default: begin
          phase_next = PH_DONE;
        end
      endcase
    end
  end

  // result of the current byte
  always_comb begin
    res_valid = 1'b0;
    res_char  = {msg_bit, accum[6:1]};
    res_last  = remaining_sub < CHAR_BITS;
    unique case (phase)
      PH_DATA: res_valid = move && (bit_count == CHAR_LAST_BIT);
      PH_HEAD, PH_LEN, PH_DONE: res_valid = 1'b0;
      default: res_valid = 1'b0;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEAD;
      byte_position <= '0;
      offset        <= '0;
      length        <= '0;
      remaining     <= '0;
      bit_count     <= '0;
      accum         <= '0;
    end else begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      offset        <= offset_next;
      length        <= length_next;
      remaining     <= remaining_next;
      bit_count     <= bit_count_next;
      accum         <= accum_next;
    end
  end

  // result register transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (!char_valid || !char_stall) begin
      char_valid <= res_valid;
    end
    if (res_valid) begin
      character      <= res_char;
      last_character <= res_last;
    end
  end

  // results only come out of the data phase
  a_res_in_data: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (phase == PH_DATA && move))
    else $error("result outside data phase");

  // done phase is final until reset
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE) |=> (phase == PH_DONE))
    else $error("left done phase");

  // the byte position only moves in the header phase
  a_pos_hold: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_HEAD) |=> $stable(byte_position))
    else $error("byte position moved after header");

  // the flagged character ends the message
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_last) |=> (phase == PH_DONE))
    else $error("last character did not end message");

  // a byte waiting at the input with a free result slot is always taken
  a_no_dead_stall: assert property (@(posedge clk) disable iff (rst)
    (in_valid_q && !char_valid) |-> !byte_stall)
    else $error("input stalled with empty result register");

endmodule
